// File: sv/sic_pkg.sv
// Shared types and constants of the segment intersection classifier.
`default_nettype none

package sic_pkg;

  // Coordinate and point formats.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int POINT_BITS = 24;
  localparam int LIMIT_BITS = 33;

  // Derived datapath widths.
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int REM_BITS  = SUM_BITS + 1;
  localparam int QUO_BITS  = DIFF_BITS + FRAC_BITS;
  localparam int CMP_BITS  = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;
  localparam int VAL_BITS  = (COORD_BITS + FRAC_BITS + 2 > POINT_BITS + 1) ?
                             COORD_BITS + FRAC_BITS + 2 : POINT_BITS + 1;
  localparam int PT_MAX_I  = 2 ** (POINT_BITS - 1) - 1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_ZERO = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLLINEAR = 1'd1;

  typedef enum logic [2:0] {
    REL_PARALLEL    = 3'd0,
    REL_CROSSING    = 3'd1,
    REL_OUTSIDE     = 3'd2,
    REL_TOUCH_START = 3'd3,
    REL_TOUCH_END   = 3'd4,
    REL_OVERLAP     = 3'd5,
    REL_DISJOINT    = 3'd6
  } relation_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } in_word_t;

  typedef struct packed {
    relation_t                    relation;
    logic                         hit;
    logic                         point_valid;
    logic signed [POINT_BITS-1:0] point_x;
    logic signed [POINT_BITS-1:0] point_y;
  } out_word_t;

  // Result flags that ride along with the division.
  typedef struct packed {
    relation_t relation;
    logic      hit;
    logic      point_valid;
  } tag_t;

  // Word carried through the division stages.
  typedef struct packed {
    tag_t                         tag;
    logic [SUM_BITS-1:0]          den;
    logic [SUM_BITS-1:0]          num;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic                         neg_x;
    logic                         neg_y;
    logic [QUO_BITS-1:0]          m_x;
    logic [QUO_BITS-1:0]          m_y;
    logic [QUO_BITS-1:0]          q_x;
    logic [QUO_BITS-1:0]          q_y;
    logic [REM_BITS-1:0]          r_x;
    logic [REM_BITS-1:0]          r_y;
  } div_t;

endpackage

`default_nettype wire

// File: sv/sic_div_step.sv
// One registered step of the interpolation divider, for both coordinates.
`default_nettype none

module sic_div_step (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire sic_pkg::div_t in_st,
  output logic              out_valid_r,
  output sic_pkg::div_t     out_st_r
);

  sic_pkg::div_t st_nxt;

  // Adds the next multiplier bit times the numerator to the doubled
  // remainder, then takes out zero, one or two denominators.
  function automatic logic [sic_pkg::REM_BITS+sic_pkg::QUO_BITS-1:0] step(
    input logic [sic_pkg::REM_BITS-1:0] r,
    input logic [sic_pkg::QUO_BITS-1:0] q,
    input logic                         mbit,
    input logic [sic_pkg::SUM_BITS-1:0] den,
    input logic [sic_pkg::SUM_BITS-1:0] num
  );
    logic [sic_pkg::REM_BITS-1:0] t;
    logic [sic_pkg::REM_BITS-1:0] d1;
    logic [sic_pkg::REM_BITS-1:0] d2;
    logic [sic_pkg::REM_BITS-1:0] rn;
    logic [1:0]                   k;
    logic [sic_pkg::QUO_BITS-1:0] qn;
    t  = {r[sic_pkg::REM_BITS-2:0], 1'b0} +
         (mbit ? sic_pkg::REM_BITS'(num) : '0);
    d1 = sic_pkg::REM_BITS'(den);
    d2 = {den, 1'b0};
    if (t >= d2) begin
      rn = t - d2;
      k  = 2'd2;
    end else if (t >= d1) begin
      rn = t - d1;
      k  = 2'd1;
    end else begin
      rn = t;
      k  = 2'd0;
    end
    qn = {q[sic_pkg::QUO_BITS-2:0], 1'b0} + sic_pkg::QUO_BITS'(k);
    return {rn, qn};
  endfunction

  // Next word of this step.
  always_comb begin
    st_nxt = in_st;
    {st_nxt.r_x, st_nxt.q_x} = step(in_st.r_x, in_st.q_x,
                                    in_st.m_x[sic_pkg::QUO_BITS-1], in_st.den, in_st.num);
    {st_nxt.r_y, st_nxt.q_y} = step(in_st.r_y, in_st.q_y,
                                    in_st.m_y[sic_pkg::QUO_BITS-1], in_st.den, in_st.num);
    st_nxt.m_x = in_st.m_x << 1;
    st_nxt.m_y = in_st.m_y << 1;
  end

  // Valid bit of the step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  // Data of the step.
  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/segment_intersection_classifier.sv
// Top level of the segment intersection classifier pipeline.
//
// Each input word holds two segments A and B as signed integer endpoints.
// Each output word gives the relation of the pair, a hit flag and, when
// point_valid is set, a point with FRAC_BITS fraction bits (zero otherwise).
// Both channels use valid/ready; a word moves when both are high.
// The configuration port writes near_zero_limit (index 0) and
// collinear_limit (index 1) whenever cfg_we is high; write it
// only while no words are in flight.
// The pipeline holds five geometry stages, one stage per quotient bit of
// the interpolation divider, and the output register.
// Throughput is one word per cycle. Every stage has its own valid bit and
// takes a new word when it is empty or its successor moves, so bubbles close
// up and a stalled receiver only backs the pipeline up; when all stages are
// full in_ready drops. Reset empties the pipeline and sets near_zero_limit
// to 1 and collinear_limit to 0.
`default_nettype none

module segment_intersection_classifier (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire sic_pkg::in_word_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output sic_pkg::out_word_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [sic_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [sic_pkg::LIMIT_BITS-1:0]       cfg_data
);

  localparam int CB = sic_pkg::COORD_BITS;
  localparam int DB = sic_pkg::DIFF_BITS;
  localparam int PB = sic_pkg::PROD_BITS;
  localparam int SB = sic_pkg::SUM_BITS;
  localparam int QB = sic_pkg::QUO_BITS;
  localparam int MB = sic_pkg::CMP_BITS;
  localparam int VB = sic_pkg::VAL_BITS;
  localparam int PTB = sic_pkg::POINT_BITS;

  typedef enum logic [1:0] {
    SEG_OFF    = 2'd0,
    SEG_START  = 2'd1,
    SEG_END    = 2'd2,
    SEG_INSIDE = 2'd3
  } seg_t;

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] bsx;
    logic signed [CB-1:0] bsy;
    logic signed [CB-1:0] bex;
    logic signed [CB-1:0] bey;
  } coords_t;

  typedef struct packed {
    logic signed [DB-1:0] dax;
    logic signed [DB-1:0] day;
    logic signed [DB-1:0] dbx;
    logic signed [DB-1:0] dby;
  } deltas_t;

  // Configuration registers.
  logic [sic_pkg::LIMIT_BITS-1:0] near_zero_limit_r;
  logic [sic_pkg::LIMIT_BITS-1:0] collinear_limit_r;

  // Stage enables.
  logic en1, en2, en3, en4, en5, en_out;
  logic en_div [QB];

  // Stage 1: differences.
  logic                 v1_r;
  logic signed [DB-1:0] dcx1_r, dcy1_r, dex1_r, dey1_r;
  deltas_t              dl1_r;
  coords_t              co1_r;

  // Stage 2: products.
  logic                 v2_r;
  logic signed [PB-1:0] pd1_r, pd2_r, pa1_r, pa2_r, pb1_r, pb2_r;
  logic signed [PB-1:0] pce1_r, pce2_r, pds1_r, pds2_r, pde1_r, pde2_r;
  logic signed [PB-1:0] pk1_r, pk2_r;
  deltas_t              dl2_r;
  coords_t              co2_r;

  // Stage 3: sums.
  logic                 v3_r;
  logic signed [SB-1:0] d3_r, na3_r, nb3_r, ce3_r, ds3_r, de3_r, kab3_r;
  deltas_t              dl3_r;
  coords_t              co3_r;

  // Stage 4: zero tests, endpoint tests and sign normalization.
  logic                 v4_r;
  logic                 nzd4_r, nzna4_r, nznb4_r;
  seg_t                 bs4_r, be4_r;
  logic signed [SB-1:0] dn4_r, nan4_r, nbn4_r;
  deltas_t              dl4_r;
  coords_t              co4_r;

  // Stage 5 and the divider chain.
  logic                 v5_r;
  sic_pkg::div_t        st5_r;
  sic_pkg::div_t        st5_nxt;
  logic                 div_v  [QB];
  sic_pkg::div_t        div_st [QB];

  // Output register.
  logic                 out_valid_r;
  sic_pkg::out_word_t   out_word_r;
  sic_pkg::out_word_t   out_nxt;

  function automatic logic [MB-1:0] mag(input logic signed [SB-1:0] v);
    logic signed [SB-1:0] n;
    n = -v;
    return v[SB-1] ? MB'($unsigned(n)) : MB'($unsigned(v));
  endfunction

  function automatic logic near_zero(input logic signed [SB-1:0] v,
                                     input logic [sic_pkg::LIMIT_BITS-1:0] lim);
    return (v == '0) || (mag(v) < MB'(lim));
  endfunction

  // Where a point lies on segment A, given its cross and dot products.
  function automatic seg_t on_seg(input logic [MB-1:0] cr_mag,
                                  input logic signed [SB-1:0] dot,
                                  input logic signed [SB-1:0] kab,
                                  input logic [sic_pkg::LIMIT_BITS-1:0] lim);
    seg_t s;
    if (cr_mag > MB'(lim) || dot < 0 || dot > kab) begin
      s = SEG_OFF;
    end else if (dot == '0) begin
      s = SEG_START;
    end else if (dot == kab) begin
      s = SEG_END;
    end else begin
      s = SEG_INSIDE;
    end
    return s;
  endfunction

  function automatic logic [QB-1:0] scaled_mag(input logic signed [DB-1:0] v);
    logic signed [DB-1:0] n;
    n = -v;
    return (v[DB-1] ? QB'($unsigned(n)) : QB'($unsigned(v))) << sic_pkg::FRAC_BITS;
  endfunction

  // Base times the scale, plus or minus the quotient, saturated.
  function automatic logic signed [PTB-1:0] point(input logic signed [CB-1:0] base,
                                                  input logic neg,
                                                  input logic [QB-1:0] q);
    logic signed [VB-1:0] v;
    logic signed [VB-1:0] qv;
    logic signed [PTB-1:0] p;
    qv = $signed(VB'(q));
    v  = VB'(base) <<< sic_pkg::FRAC_BITS;
    v  = neg ? v - qv : v + qv;
    if (v > VB'(sic_pkg::PT_MAX_I)) begin
      p = PTB'(sic_pkg::PT_MAX_I);
    end else if (v < VB'(-sic_pkg::PT_MAX_I - 1)) begin
      p = PTB'(-sic_pkg::PT_MAX_I - 1);
    end else begin
      p = v[PTB-1:0];
    end
    return p;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_zero_limit_r <= sic_pkg::LIMIT_BITS'(1);
      collinear_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sic_pkg::CFG_NEAR_ZERO: near_zero_limit_r <= cfg_data;
        sic_pkg::CFG_COLLINEAR: collinear_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its word moves on.
  assign en_out = !out_valid_r || out_ready;

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_en
      if (k == QB - 1) begin : g_last
        assign en_div[k] = !div_v[k] || en_out;
      end else begin : g_mid
        assign en_div[k] = !div_v[k] || en_div[k+1];
      end
    end
  endgenerate

  assign en5      = !v5_r || en_div[0];
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Valid bits of the geometry stages and the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en_out) out_valid_r <= div_v[QB-1];
    end
  end

  // Stage 1: endpoint differences.
  always_ff @(posedge clk) begin
    if (en1) begin
      dl1_r.dax <= DB'(in_data.a_end_x) - DB'(in_data.a_start_x);
      dl1_r.day <= DB'(in_data.a_end_y) - DB'(in_data.a_start_y);
      dl1_r.dbx <= DB'(in_data.b_end_x) - DB'(in_data.b_start_x);
      dl1_r.dby <= DB'(in_data.b_end_y) - DB'(in_data.b_start_y);
      dcx1_r    <= DB'(in_data.a_start_x) - DB'(in_data.b_start_x);
      dcy1_r    <= DB'(in_data.a_start_y) - DB'(in_data.b_start_y);
      dex1_r    <= DB'(in_data.b_end_x) - DB'(in_data.a_start_x);
      dey1_r    <= DB'(in_data.b_end_y) - DB'(in_data.a_start_y);
      co1_r.ax  <= in_data.a_start_x;
      co1_r.ay  <= in_data.a_start_y;
      co1_r.bsx <= in_data.b_start_x;
      co1_r.bsy <= in_data.b_start_y;
      co1_r.bex <= in_data.b_end_x;
      co1_r.bey <= in_data.b_end_y;
    end
  end

  // Stage 2: all products.
  always_ff @(posedge clk) begin
    if (en2) begin
      pd1_r  <= PB'(dl1_r.dby) * PB'(dl1_r.dax);
      pd2_r  <= PB'(dl1_r.dbx) * PB'(dl1_r.day);
      pa1_r  <= PB'(dl1_r.dbx) * PB'(dcy1_r);
      pa2_r  <= PB'(dl1_r.dby) * PB'(dcx1_r);
      pb1_r  <= PB'(dl1_r.dax) * PB'(dcy1_r);
      pb2_r  <= PB'(dl1_r.day) * PB'(dcx1_r);
      pce1_r <= PB'(dl1_r.dax) * PB'(dey1_r);
      pce2_r <= PB'(dl1_r.day) * PB'(dex1_r);
      pds1_r <= PB'(dl1_r.dax) * PB'(dcx1_r);
      pds2_r <= PB'(dl1_r.day) * PB'(dcy1_r);
      pde1_r <= PB'(dl1_r.dax) * PB'(dex1_r);
      pde2_r <= PB'(dl1_r.day) * PB'(dey1_r);
      pk1_r  <= PB'(dl1_r.dax) * PB'(dl1_r.dax);
      pk2_r  <= PB'(dl1_r.day) * PB'(dl1_r.day);
      dl2_r  <= dl1_r;
      co2_r  <= co1_r;
    end
  end

  // Stage 3: denominator, numerators, cross and dot products.
  always_ff @(posedge clk) begin
    if (en3) begin
      d3_r   <= SB'(pd1_r) - SB'(pd2_r);
      na3_r  <= SB'(pa1_r) - SB'(pa2_r);
      nb3_r  <= SB'(pb1_r) - SB'(pb2_r);
      ce3_r  <= SB'(pce1_r) - SB'(pce2_r);
      ds3_r  <= -(SB'(pds1_r) + SB'(pds2_r));
      de3_r  <= SB'(pde1_r) + SB'(pde2_r);
      kab3_r <= SB'(pk1_r) + SB'(pk2_r);
      dl3_r  <= dl2_r;
      co3_r  <= co2_r;
    end
  end

  // Stage 4: zero tests, endpoint tests and sign normalization. The cross
  // product for b_start is the negated second numerator.
  always_ff @(posedge clk) begin
    if (en4) begin
      nzd4_r  <= near_zero(d3_r, near_zero_limit_r);
      nzna4_r <= near_zero(na3_r, near_zero_limit_r);
      nznb4_r <= near_zero(nb3_r, near_zero_limit_r);
      bs4_r   <= on_seg(mag(nb3_r), ds3_r, kab3_r, collinear_limit_r);
      be4_r   <= on_seg(mag(ce3_r), de3_r, kab3_r, collinear_limit_r);
      dn4_r   <= d3_r[SB-1] ? -d3_r : d3_r;
      nan4_r  <= d3_r[SB-1] ? -na3_r : na3_r;
      nbn4_r  <= d3_r[SB-1] ? -nb3_r : nb3_r;
      dl4_r   <= dl3_r;
      co4_r   <= co3_r;
    end
  end

  // Stage 5: classify and set up the interpolation. Paths without a
  // division use a zero numerator over one, which yields a zero quotient.
  always_comb begin
    logic ina;
    logic inb;
    ina = !nan4_r[SB-1] && (nan4_r <= dn4_r);
    inb = !nbn4_r[SB-1] && (nbn4_r <= dn4_r);
    st5_nxt = '0;
    st5_nxt.den = SB'(1);
    st5_nxt.tag.relation = sic_pkg::REL_PARALLEL;
    if (nzd4_r && (nzna4_r || nznb4_r)) begin
      if (bs4_r == SEG_START || bs4_r == SEG_END) begin
        st5_nxt.tag.relation    = sic_pkg::REL_TOUCH_START;
        st5_nxt.tag.point_valid = 1'b1;
        st5_nxt.base_x          = co4_r.bsx;
        st5_nxt.base_y          = co4_r.bsy;
      end else if (bs4_r == SEG_INSIDE) begin
        st5_nxt.tag.relation = sic_pkg::REL_OVERLAP;
      end else if (be4_r == SEG_START || be4_r == SEG_END) begin
        st5_nxt.tag.relation    = sic_pkg::REL_TOUCH_END;
        st5_nxt.tag.point_valid = 1'b1;
        st5_nxt.base_x          = co4_r.bex;
        st5_nxt.base_y          = co4_r.bey;
      end else if (be4_r == SEG_INSIDE) begin
        st5_nxt.tag.relation = sic_pkg::REL_OVERLAP;
      end else begin
        st5_nxt.tag.relation = sic_pkg::REL_DISJOINT;
      end
      st5_nxt.tag.hit = (st5_nxt.tag.relation != sic_pkg::REL_DISJOINT);
    end else if (!nzd4_r) begin
      st5_nxt.tag.relation = (ina && inb) ? sic_pkg::REL_CROSSING : sic_pkg::REL_OUTSIDE;
      st5_nxt.tag.hit      = ina && inb;
      if (inb && !ina) begin
        st5_nxt.tag.point_valid = 1'b1;
        st5_nxt.den    = $unsigned(dn4_r);
        st5_nxt.num    = $unsigned(nbn4_r);
        st5_nxt.base_x = co4_r.bsx;
        st5_nxt.base_y = co4_r.bsy;
        st5_nxt.neg_x  = dl4_r.dbx[DB-1];
        st5_nxt.neg_y  = dl4_r.dby[DB-1];
        st5_nxt.m_x    = scaled_mag(dl4_r.dbx);
        st5_nxt.m_y    = scaled_mag(dl4_r.dby);
      end else if (ina) begin
        st5_nxt.tag.point_valid = 1'b1;
        st5_nxt.den    = $unsigned(dn4_r);
        st5_nxt.num    = $unsigned(nan4_r);
        st5_nxt.base_x = co4_r.ax;
        st5_nxt.base_y = co4_r.ay;
        st5_nxt.neg_x  = dl4_r.dax[DB-1];
        st5_nxt.neg_y  = dl4_r.day[DB-1];
        st5_nxt.m_x    = scaled_mag(dl4_r.dax);
        st5_nxt.m_y    = scaled_mag(dl4_r.day);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      st5_r <= st5_nxt;
    end
  end

  // Divider chain: one quotient bit per stage.
  generate
    for (k = 0; k < QB; k++) begin : g_div
      if (k == 0) begin : g_first
        sic_div_step u_step (
          .clk        (clk),
          .rst_n      (rst_n),
          .en         (en_div[k]),
          .in_valid   (v5_r),
          .in_st      (st5_r),
          .out_valid_r(div_v[k]),
          .out_st_r   (div_st[k])
        );
      end else begin : g_next
        sic_div_step u_step (
          .clk        (clk),
          .rst_n      (rst_n),
          .en         (en_div[k]),
          .in_valid   (div_v[k-1]),
          .in_st      (div_st[k-1]),
          .out_valid_r(div_v[k]),
          .out_st_r   (div_st[k])
        );
      end
    end
  endgenerate

  // Output: form the points and zero them when there is none.
  always_comb begin
    out_nxt.relation    = div_st[QB-1].tag.relation;
    out_nxt.hit         = div_st[QB-1].tag.hit;
    out_nxt.point_valid = div_st[QB-1].tag.point_valid;
    out_nxt.point_x     = '0;
    out_nxt.point_y     = '0;
    if (div_st[QB-1].tag.point_valid) begin
      out_nxt.point_x = point(div_st[QB-1].base_x, div_st[QB-1].neg_x, div_st[QB-1].q_x);
      out_nxt.point_y = point(div_st[QB-1].base_y, div_st[QB-1].neg_y, div_st[QB-1].q_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // A hit is only reported for crossing, touching or overlapping pairs.
  a_hit_relation : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.hit) |->
      (out_word_r.relation == sic_pkg::REL_CROSSING ||
       out_word_r.relation == sic_pkg::REL_TOUCH_START ||
       out_word_r.relation == sic_pkg::REL_TOUCH_END ||
       out_word_r.relation == sic_pkg::REL_OVERLAP))
    else $error("hit set for a relation without contact");

  // Without a point both coordinates are zero.
  a_no_point_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.point_valid) |->
      (out_word_r.point_x == '0 && out_word_r.point_y == '0))
    else $error("point coordinates not cleared");

  // Relations that never carry a point.
  a_point_relation : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.relation == sic_pkg::REL_PARALLEL ||
                     out_word_r.relation == sic_pkg::REL_OVERLAP ||
                     out_word_r.relation == sic_pkg::REL_DISJOINT)) |->
      !out_word_r.point_valid)
    else $error("point given for a relation without one");

  // The input is only held off when the output is stalled.
  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled while the output moves");

endmodule

`default_nettype wire

// File: sim/segment_intersection_classifier_test.sv
// Self-checking testbench of the segment intersection classifier.
`default_nettype none

module segment_intersection_classifier_test;

  localparam int PIPE_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sic_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  sic_pkg::out_word_t out_data;
  logic cfg_we;
  logic [sic_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [sic_pkg::LIMIT_BITS-1:0] cfg_data;

  segment_intersection_classifier u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the two limits.
  longint unsigned zero_lim;
  longint unsigned coll_lim;

  sic_pkg::in_word_t  pair_queue[$];
  sic_pkg::out_word_t expected_words[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int rel_seen[7];
  int idle_cycles;
  bit timed_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned mag_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic bit is_zero(longint v);
    return v == 0 || mag_of(v) < zero_lim;
  endfunction

  // 0 off A, 1 at A start, 2 at A end, 3 inside A.
  function automatic int where_on_a(longint x0, longint y0, longint x1, longint y1,
                                    longint px, longint py);
    longint dx, dy, qx, qy, cr, dt, len2;
    dx = x1 - x0; dy = y1 - y0; qx = px - x0; qy = py - y0;
    cr = dx * qy - dy * qx;
    if (mag_of(cr) > coll_lim) return 0;
    dt = dx * qx + dy * qy;
    if (dt < 0) return 0;
    if (dt == 0) return 1;
    len2 = dx * dx + dy * dy;
    if (dt > len2) return 0;
    if (dt == len2) return 2;
    return 3;
  endfunction

  // base * 2^FRAC + trunc(n * delta * 2^FRAC / d), saturated to the point range.
  function automatic logic signed [sic_pkg::POINT_BITS-1:0] interp(longint base, longint n,
                                                                    longint d, longint delta);
    logic signed [127:0] prod, v;
    prod = (128'(n) * 128'(mag_of(delta)) * (128'sd1 <<< sic_pkg::FRAC_BITS)) / 128'(d);
    v = 128'(base) * (128'sd1 <<< sic_pkg::FRAC_BITS);
    v = (delta < 0) ? v - prod : v + prod;
    if (v > sic_pkg::PT_MAX_I) v = sic_pkg::PT_MAX_I;
    if (v < -sic_pkg::PT_MAX_I - 1) v = -sic_pkg::PT_MAX_I - 1;
    return v[sic_pkg::POINT_BITS-1:0];
  endfunction

  function automatic sic_pkg::out_word_t classify(sic_pkg::in_word_t w);
    sic_pkg::out_word_t r;
    longint x1, y1, x2, y2, x3, y3, x4, y4, den, na, nb;
    int s;
    bit ina, inb;
    x1 = w.a_start_x; y1 = w.a_start_y; x2 = w.a_end_x; y2 = w.a_end_y;
    x3 = w.b_start_x; y3 = w.b_start_y; x4 = w.b_end_x; y4 = w.b_end_y;
    den = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
    na = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
    nb = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
    r = '0;
    r.relation = sic_pkg::REL_PARALLEL;
    if (is_zero(den) && (is_zero(na) || is_zero(nb))) begin
      s = where_on_a(x1, y1, x2, y2, x3, y3);
      if (s == 1 || s == 2) begin
        r.relation = sic_pkg::REL_TOUCH_START;
        r.point_valid = 1'b1;
        r.point_x = interp(x3, 0, 1, 0);
        r.point_y = interp(y3, 0, 1, 0);
      end else if (s == 3) begin
        r.relation = sic_pkg::REL_OVERLAP;
      end else begin
        s = where_on_a(x1, y1, x2, y2, x4, y4);
        if (s == 1 || s == 2) begin
          r.relation = sic_pkg::REL_TOUCH_END;
          r.point_valid = 1'b1;
          r.point_x = interp(x4, 0, 1, 0);
          r.point_y = interp(y4, 0, 1, 0);
        end else if (s == 3) r.relation = sic_pkg::REL_OVERLAP;
        else r.relation = sic_pkg::REL_DISJOINT;
      end
      r.hit = (r.relation != sic_pkg::REL_DISJOINT);
    end else if (!is_zero(den)) begin
      if (den < 0) begin
        den = -den; na = -na; nb = -nb;
      end
      ina = na >= 0 && na <= den;
      inb = nb >= 0 && nb <= den;
      r.relation = (ina && inb) ? sic_pkg::REL_CROSSING : sic_pkg::REL_OUTSIDE;
      r.hit = ina && inb;
      if (inb && !ina) begin
        r.point_valid = 1'b1;
        r.point_x = interp(x3, nb, den, x4 - x3);
        r.point_y = interp(y3, nb, den, y4 - y3);
      end else if (ina) begin
        r.point_valid = 1'b1;
        r.point_x = interp(x1, na, den, x2 - x1);
        r.point_y = interp(y1, na, den, y2 - y1);
      end
    end
    return r;
  endfunction

  // Random coordinate: mostly small, sometimes the full range or an extreme.
  function automatic logic [sic_pkg::COORD_BITS-1:0] coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic sic_pkg::in_word_t random_pair();
    sic_pkg::in_word_t w;
    int k, t0, t1;
    w.a_start_x = coord(); w.a_start_y = coord();
    w.a_end_x = coord(); w.a_end_y = coord();
    w.b_start_x = coord(); w.b_start_y = coord();
    w.b_end_x = coord(); w.b_end_y = coord();
    k = $urandom_range(0, 9);
    if (k < 4) begin
      // B on the line of A, at small integer multiples of a step.
      t0 = $urandom_range(0, 8) - 3; t1 = $urandom_range(0, 8) - 3;
      w.a_end_x = w.a_start_x + 16'($urandom_range(0, 6)) - 16'sd3;
      w.a_end_y = w.a_start_y + 16'($urandom_range(0, 6)) - 16'sd3;
      w.a_end_x = 16'(w.a_start_x + 2 * (w.a_end_x - w.a_start_x));
      w.a_end_y = 16'(w.a_start_y + 2 * (w.a_end_y - w.a_start_y));
      w.b_start_x = 16'(w.a_start_x + t0 * (w.a_end_x - w.a_start_x) / 2);
      w.b_start_y = 16'(w.a_start_y + t0 * (w.a_end_y - w.a_start_y) / 2);
      w.b_end_x = 16'(w.a_start_x + t1 * (w.a_end_x - w.a_start_x) / 2);
      w.b_end_y = 16'(w.a_start_y + t1 * (w.a_end_y - w.a_start_y) / 2);
      if (k == 0) w.b_end_y += 16'sd1;
    end else if (k == 4) begin
      // Parallel offset copy of A.
      w.b_start_x = w.a_start_x + 16'sd3;
      w.b_end_x = w.a_end_x + 16'sd3;
      w.b_start_y = w.a_start_y;
      w.b_end_y = w.a_end_y;
    end
    return w;
  endfunction

  function automatic sic_pkg::in_word_t mk(int ax0, int ay0, int ax1, int ay1,
                                           int bx0, int by0, int bx1, int by1);
    sic_pkg::in_word_t w;
    w = {16'(ax0), 16'(ay0), 16'(ax1), 16'(ay1),
         16'(bx0), 16'(by0), 16'(bx1), 16'(by1)};
    return w;
  endfunction

  // Driver: presents queued pairs with random gaps between them.
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
      // Hold the word until it is taken.
    end else begin
      if (in_valid) begin
        expected_words.push_back(classify(in_data));
        n_sent <= n_sent + 1;
      end
      if (gap_left > 0 || pair_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= pair_queue.pop_front();
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  int stall_left;
  sic_pkg::out_word_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", out_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          n_checked++;
          rel_seen[want.relation]++;
          if (out_data.relation !== want.relation) begin
            $error("relation: expected %0d, got %0d", want.relation, out_data.relation);
            errors++;
          end
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
            errors++;
          end
          if (out_data.point_valid !== want.point_valid) begin
            $error("point_valid: expected %0d, got %0d",
                   want.point_valid, out_data.point_valid);
            errors++;
          end
          if (out_data.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, out_data.point_x);
            errors++;
          end
          if (out_data.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, out_data.point_y);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!out_ready || out_valid) begin
        out_ready <= 1'b1;
        if (out_valid && $urandom_range(0, 2) != 0) stall_left <= $urandom_range(0, 14);
      end
    end
  end

  // Watchdog on cycles with no word accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      timed_out = 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_limit(logic [sic_pkg::CFG_IDX_BITS-1:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[sic_pkg::LIMIT_BITS-1:0];
    if (idx == sic_pkg::CFG_NEAR_ZERO) zero_lim = val;
    else coll_lim = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word has been sent and checked.
  task automatic drain();
    while (pair_queue.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) pair_queue.push_back(random_pair());
  endtask

  longint unsigned zero_set[4] = '{1, 0, 64, 33'h1_ffff_ffff};
  longint unsigned coll_set[4] = '{0, 2, 300, 33'h1_ffff_ffff};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sic_pkg::CFG_NEAR_ZERO;
    cfg_data = '0;
    zero_lim = 1;
    coll_lim = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs at reset limits: each relation and the field extremes.
    pair_queue.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));
    pair_queue.push_back(mk(0, 0, 10, 0, 20, -5, 20, 5));
    pair_queue.push_back(mk(0, 0, 10, 0, 5, 3, 5, 30));
    pair_queue.push_back(mk(0, 0, 1, 0, 50, 3, 60, 40));
    pair_queue.push_back(mk(0, 0, 10, 0, 0, 1, 10, 1));
    pair_queue.push_back(mk(0, 0, 10, 0, 10, 0, 20, 0));
    pair_queue.push_back(mk(0, 0, 10, 0, 0, 0, -5, 0));
    pair_queue.push_back(mk(0, 0, 10, 0, 20, 0, 10, 0));
    pair_queue.push_back(mk(0, 0, 10, 0, 3, 0, 7, 0));
    pair_queue.push_back(mk(0, 0, 10, 0, -5, 0, 5, 0));
    pair_queue.push_back(mk(0, 0, 10, 0, 20, 0, 30, 0));
    pair_queue.push_back(mk(5, 5, 5, 5, 5, 5, 5, 5));
    pair_queue.push_back(mk(5, 5, 5, 5, 9, 9, 9, 9));
    pair_queue.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pair_queue.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    pair_queue.push_back(mk(-32768, 0, 32767, 0, -32768, 0, 32767, 0));
    pair_queue.push_back(mk(0, 0, 3, 1, 1, 2, 2, -7));
    pair_queue.push_back(mk(0, 0, -7, 3, -1, 5, 2, -9));
    pair_queue.push_back(mk(-1, -1, -1, -1, 0, 0, 0, 0));
    pair_queue.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768));
    drain();

    // Random phases over a sweep of limits, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(sic_pkg::CFG_NEAR_ZERO, zero_set[ph % 4]);
      write_limit(sic_pkg::CFG_COLLINEAR, coll_set[(ph + ph / 4) % 4]);
      queue_random(155);
      drain();
    end
    write_limit(sic_pkg::CFG_NEAR_ZERO, 1);
    write_limit(sic_pkg::CFG_COLLINEAR, 0);
    queue_random(20);
    drain();

    $display("Checked %0d of %0d pairs over nine limit settings.", n_checked, n_sent);
    $display("Relations 0..6 seen: %0d %0d %0d %0d %0d %0d %0d", rel_seen[0], rel_seen[1],
             rel_seen[2], rel_seen[3], rel_seen[4], rel_seen[5], rel_seen[6]);
    if (errors == 0 && !timed_out) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire
